### rtl/quadratic_root_solver_macros.svh
// Assertion macros shared by the quadratic root solver RTL
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// same-cycle implication, off during reset
`define QRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, live during reset
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qrs_pkg.sv
// Types, widths and step functions of the quadratic root solver
package qrs_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = 2 * COEF_W;
    localparam int DISC_PAIRS    = 17;
    localparam int DISC_W        = 2 * DISC_PAIRS;
    localparam int SQ_STEPS      = DISC_PAIRS + FRACTION_BITS;
    localparam int ROOT_W        = SQ_STEPS;
    localparam int REM_W         = ROOT_W + 2;
    localparam int NUM_W         = ROOT_W + 1;
    localparam int SNUM_W        = NUM_W + 1;
    localparam int DEN_W         = COEF_W + 1;
    localparam int DREM_W        = DEN_W + 1;
    localparam int ROOT_OUT_W    = 50;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEG   = 2'd1,
        ST_AZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } front_t;

    typedef struct packed {
        logic                     valid;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [PROD_W-1:0] bb;
        logic signed [PROD_W-1:0] ac;
    } prod_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic [DISC_W-1:0]        d;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [COEF_W-1:0] b;
        logic                     neg_a;
        logic [DEN_W-1:0]         den;
    } sq_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic              neg_p;
        logic              neg_m;
        logic [DEN_W-1:0]  den;
        logic [DREM_W-1:0] rp;
        logic [DREM_W-1:0] rm;
        logic [NUM_W-1:0]  qp;
        logic [NUM_W-1:0]  qm;
    } dv_t;

    // one digit of the square root: bring down two bits, try 4*root+1
    function automatic sq_t sq_step(sq_t x);
        logic [REM_W+1:0] rs;
        logic [REM_W+1:0] trial;
        sq_t              y;
        y     = x;
        rs    = {x.rem, x.d[DISC_W-1 -: 2]};
        trial = {2'b00, x.root, 2'b01};
        y.d   = {x.d[DISC_W-3:0], 2'b00};
        if (rs >= trial) begin
            y.rem  = REM_W'(rs - trial);
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end else begin
            y.rem  = REM_W'(rs);
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    // one quotient bit of restoring division; dividend shifts out of q as quotient shifts in
    function automatic logic [DREM_W+NUM_W-1:0] div_bit(logic [DREM_W-1:0] r,
                                                        logic [NUM_W-1:0]  q,
                                                        logic [DEN_W-1:0]  den);
        logic [DREM_W-1:0] rs;
        logic [DREM_W-1:0] dd;
        logic              hit;
        rs  = {r[DREM_W-2:0], q[NUM_W-1]};
        dd  = {1'b0, den};
        hit = (rs >= dd);
        return {(hit ? rs - dd : rs), q[NUM_W-2:0], hit};
    endfunction

    function automatic dv_t dv_step(dv_t x);
        dv_t y;
        y = x;
        {y.rp, y.qp} = div_bit(x.rp, x.qp, x.den);
        {y.rm, y.qm} = div_bit(x.rm, x.qm, x.den);
        return y;
    endfunction

endpackage

### rtl/quadratic_root_solver.sv
// Quadratic root solver: pipelined discriminant, square root and dividers
// Takes signed 16-bit a, b, c and returns both real roots (-b +/- sqrt(b*b-4ac))/(2a) in
// signed fixed point with 16 fraction bits (floor square root, division truncated toward
// zero), or status 1 when the discriminant is negative, 2 when a is zero (roots then 0 in both cases).
// One beat is accepted every cycle while the pipeline is not held; stages: input and multiply registers,
// the discriminant stage, 33 square-root digit stages, a numerator stage, 34 quotient-bit
// stages of the two dividers and the output register. The whole pipeline holds while the
// output register is full and not taken.
`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [qrs_pkg::COEF_W-1:0]      s_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]      s_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]      s_coef_c,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_status,
    output logic signed [qrs_pkg::ROOT_OUT_W-1:0]  m_root_plus,
    output logic signed [qrs_pkg::ROOT_OUT_W-1:0]  m_root_minus
);

    qrs_pkg::front_t front_reg;
    qrs_pkg::prod_t  prod_reg, prod_next;
    qrs_pkg::sq_t    sq_reg [qrs_pkg::SQ_STEPS+1];
    qrs_pkg::sq_t    sq0_next;
    qrs_pkg::dv_t    dv_reg [qrs_pkg::NUM_W+1];
    qrs_pkg::dv_t    dv0_next;

    logic                                   out_valid_reg;
    qrs_pkg::status_t                       out_status_reg, out_status_next;
    logic signed [qrs_pkg::ROOT_OUT_W-1:0]  out_plus_reg, out_plus_next;
    logic signed [qrs_pkg::ROOT_OUT_W-1:0]  out_minus_reg, out_minus_next;

    logic en;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // multiply stage
    always_comb begin
        prod_next.valid = front_reg.valid;
        prod_next.a     = front_reg.a;
        prod_next.b     = front_reg.b;
        prod_next.bb    = front_reg.b * front_reg.b;
        prod_next.ac    = front_reg.a * front_reg.c;
    end

    // discriminant, status and |2a|
    logic signed [qrs_pkg::DISC_W:0]  disc;
    logic signed [qrs_pkg::DEN_W-1:0] two_a;
    always_comb begin
        disc  = (qrs_pkg::DISC_W+1)'(prod_reg.bb) - ((qrs_pkg::DISC_W+1)'(prod_reg.ac) <<< 2);
        two_a = {prod_reg.a, 1'b0};
        sq0_next.valid = prod_reg.valid;
        if (prod_reg.a == '0) begin
            sq0_next.status = qrs_pkg::ST_AZERO;
        end else if (disc[qrs_pkg::DISC_W]) begin
            sq0_next.status = qrs_pkg::ST_NEG;
        end else begin
            sq0_next.status = qrs_pkg::ST_OK;
        end
        sq0_next.d     = disc[qrs_pkg::DISC_W-1:0];
        sq0_next.rem   = '0;
        sq0_next.root  = '0;
        sq0_next.b     = prod_reg.b;
        sq0_next.neg_a = prod_reg.a[qrs_pkg::COEF_W-1];
        sq0_next.den   = two_a[qrs_pkg::DEN_W-1] ? qrs_pkg::DEN_W'(-two_a)
                                                 : qrs_pkg::DEN_W'(two_a);
    end

    // numerators -b*2^F +/- s as sign and magnitude
    logic signed [qrs_pkg::SNUM_W-1:0] bs, sroot, num_p, num_m;
    always_comb begin
        bs    = qrs_pkg::SNUM_W'(sq_reg[qrs_pkg::SQ_STEPS].b) <<< qrs_pkg::FRACTION_BITS;
        sroot = {2'b00, sq_reg[qrs_pkg::SQ_STEPS].root};
        num_p = sroot - bs;
        num_m = -bs - sroot;
        dv0_next.valid  = sq_reg[qrs_pkg::SQ_STEPS].valid;
        dv0_next.status = sq_reg[qrs_pkg::SQ_STEPS].status;
        dv0_next.den    = sq_reg[qrs_pkg::SQ_STEPS].den;
        dv0_next.neg_p  = num_p[qrs_pkg::SNUM_W-1] ^ sq_reg[qrs_pkg::SQ_STEPS].neg_a;
        dv0_next.neg_m  = num_m[qrs_pkg::SNUM_W-1] ^ sq_reg[qrs_pkg::SQ_STEPS].neg_a;
        dv0_next.rp     = '0;
        dv0_next.rm     = '0;
        dv0_next.qp     = num_p[qrs_pkg::SNUM_W-1] ? qrs_pkg::NUM_W'(-num_p)
                                                   : qrs_pkg::NUM_W'(num_p);
        dv0_next.qm     = num_m[qrs_pkg::SNUM_W-1] ? qrs_pkg::NUM_W'(-num_m)
                                                   : qrs_pkg::NUM_W'(num_m);
    end

    // sign the quotients and clear roots unless status is OK
    logic signed [qrs_pkg::SNUM_W-1:0] q_p, q_m;
    always_comb begin
        q_p = {1'b0, dv_reg[qrs_pkg::NUM_W].qp};
        q_m = {1'b0, dv_reg[qrs_pkg::NUM_W].qm};
        if (dv_reg[qrs_pkg::NUM_W].neg_p) begin
            q_p = -q_p;
        end
        if (dv_reg[qrs_pkg::NUM_W].neg_m) begin
            q_m = -q_m;
        end
        out_status_next = dv_reg[qrs_pkg::NUM_W].status;
        if (dv_reg[qrs_pkg::NUM_W].status == qrs_pkg::ST_OK) begin
            out_plus_next  = qrs_pkg::ROOT_OUT_W'(q_p);
            out_minus_next = qrs_pkg::ROOT_OUT_W'(q_m);
        end else begin
            out_plus_next  = '0;
            out_minus_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
            prod_reg.valid  <= 1'b0;
            for (int k = 0; k <= qrs_pkg::SQ_STEPS; k++) begin
                sq_reg[k].valid <= 1'b0;
            end
            for (int k = 0; k <= qrs_pkg::NUM_W; k++) begin
                dv_reg[k].valid <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            front_reg.valid <= s_valid;
            front_reg.a     <= s_coef_a;
            front_reg.b     <= s_coef_b;
            front_reg.c     <= s_coef_c;
            prod_reg        <= prod_next;
            sq_reg[0]       <= sq0_next;
            for (int k = 0; k < qrs_pkg::SQ_STEPS; k++) begin
                sq_reg[k+1] <= qrs_pkg::sq_step(sq_reg[k]);
            end
            dv_reg[0] <= dv0_next;
            for (int k = 0; k < qrs_pkg::NUM_W; k++) begin
                dv_reg[k+1] <= qrs_pkg::dv_step(dv_reg[k]);
            end
            out_valid_reg  <= dv_reg[qrs_pkg::NUM_W].valid;
            out_status_reg <= out_status_next;
            out_plus_reg   <= out_plus_next;
            out_minus_reg  <= out_minus_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_root_plus  = out_plus_reg;
    assign m_root_minus = out_minus_reg;

    `QRS_ASSERT_IMP(a_zero_roots, m_valid && m_status != qrs_pkg::ST_OK, m_root_plus == '0 && m_root_minus == '0, "roots not cleared for flagged beat")
    `QRS_ASSERT_IMP(a_div_rem, dv_reg[qrs_pkg::NUM_W].valid && dv_reg[qrs_pkg::NUM_W].status == qrs_pkg::ST_OK, dv_reg[qrs_pkg::NUM_W].rp < {1'b0, dv_reg[qrs_pkg::NUM_W].den}, "divider remainder out of range")
    `QRS_ASSERT_IMP(a_azero_den, sq_reg[0].valid && sq_reg[0].status == qrs_pkg::ST_AZERO, sq_reg[0].den == '0, "zero a with nonzero divisor")
    `QRS_ASSERT_NEXT(a_reset_out, !aresetn, !m_valid, "output valid after reset")

endmodule

### tb/tb_top.sv
// Testbench for the quadratic root solver: random and directed coefficients, scoreboard check
module tb_top;

    localparam int LATENCY    = 72;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        qrs_pkg::status_t   status;
        logic signed [49:0] root_plus;
        logic signed [49:0] root_minus;
    } roots_t;

    class root_scoreboard;
        roots_t pending[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // floor(sqrt(d * 2^32)) digit by digit
        function automatic longint unsigned scaled_sqrt(longint unsigned d);
            longint unsigned r, rem, pair, trial;
            int i;
            r = 0;
            rem = 0;
            for (i = 32; i >= 0; i--) begin
                pair = (i >= 16) ? ((d >> (2 * (i - 16))) & 3) : 0;
                rem = (rem << 2) | pair;
                trial = (r << 2) | 1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    r = (r << 1) | 1;
                end else begin
                    r = r << 1;
                end
            end
            return r;
        endfunction

        function automatic longint quot_trunc(longint num, longint den);
            longint unsigned un, ud, q;
            un = (num < 0) ? -num : num;
            ud = (den < 0) ? -den : den;
            q = un / ud;
            return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function void note_coefs(shortint a, shortint b, shortint c);
            roots_t e;
            longint disc, s, bs;
            e.status = qrs_pkg::ST_OK;
            e.root_plus = '0;
            e.root_minus = '0;
            disc = longint'(b) * b - 4 * longint'(a) * c;
            if (a == 0) begin
                e.status = qrs_pkg::ST_AZERO;
            end else if (disc < 0) begin
                e.status = qrs_pkg::ST_NEG;
            end else begin
                s = longint'(scaled_sqrt(disc));
                bs = longint'(b) <<< 16;
                e.root_plus = 50'(quot_trunc(-bs + s, 2 * longint'(a)));
                e.root_minus = 50'(quot_trunc(-bs - s, 2 * longint'(a)));
            end
            pending.push_back(e);
        endfunction

        function void check_roots(logic [1:0] st, logic [49:0] rp, logic [49:0] rm);
            roots_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected beat: status %0d", $time, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t status exp %0d got %0d", $time, e.status, st);
                errors++;
            end
            if (rp !== e.root_plus) begin
                $display("%0t root_plus exp %0d got %0d", $time, e.root_plus, $signed(rp));
                errors++;
            end
            if (rm !== e.root_minus) begin
                $display("%0t root_minus exp %0d got %0d", $time, e.root_minus, $signed(rm));
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_coef_a = 0, s_coef_b = 0, s_coef_c = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [1:0] m_status;
    logic signed [49:0] m_root_plus, m_root_minus;

    root_scoreboard sb = new();
    bit sending_done = 0;
    bit hold_sink = 0;
    int idle_cycles = 0;

    quadratic_root_solver dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_coefs(shortint a, shortint b, shortint c);
        s_valid <= 1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_coefs(a, b, c);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic shortint rand_coef();
        case ($urandom_range(0, 5))
            0: return shortint'($urandom_range(0, 8)) - 4;
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return shortint'($urandom_range(0, 200)) - 100;
            default: return shortint'($urandom());
        endcase
    endfunction

    initial begin
        shortint a, b, c, k;
        shortint ex[6] = '{16'sh8000, 16'sh7fff, -1, 0, 1, 16'sh1234};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes, zero a, negative and zero discriminant
        send_coefs(1, -3, 2);
        send_coefs(1, 2, 1);
        send_coefs(1, 0, 1);
        send_coefs(0, 5, 3);
        send_coefs(0, 16'sh8000, 16'sh7fff);
        send_coefs(16'sh8000, 16'sh8000, 16'sh7fff);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
        send_coefs(16'sh8000, 16'sh7fff, 16'sh8000);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_coefs(1, 16'sh8000, 16'sh8000);
        send_coefs(-1, 16'sh7fff, 0);
        send_coefs(-1, 0, 0);
        send_coefs(1, 1, 0);
        for (int i = 0; i < 6; i++) send_coefs(ex[i], ex[5 - i], ex[(i + 2) % 6]);
        // hold the sink so the pipeline fills and backs up the input
        hold_sink = 1;
        for (int i = 0; i < 150; i++) send_coefs(rand_coef(), rand_coef(), rand_coef());
        for (int i = 0; i < 1000; i++) begin
            if (i == 500) begin
                s_valid <= 0;
                while (sb.pending.size() != 0) @(posedge aclk);
            end
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            // bias toward real roots: pick c so b*b - 4ac stays small nonnegative
            if ($urandom_range(0, 3) == 0 && a != 0) begin
                k = shortint'(($signed(b) * $signed(b)) / (4 * $signed(a)));
                c = (($signed(b) * $signed(b)) / (4 * $signed(a)) > 32767 ||
                     ($signed(b) * $signed(b)) / (4 * $signed(a)) < -32768) ? c : k;
            end
            send_coefs(a, b, c);
            pause(gap_len());
        end
        s_valid <= 0;
        sending_done = 1;
    end

    // sink: random stalls, one long forced hold-off
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
            end
            n = gap_len();
            if (n > 0) begin
                m_ready <= 0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_roots(m_status, m_root_plus, m_root_minus);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0 && idle_cycles < IDLE_LIMIT) @(posedge aclk);
        if (idle_cycles < IDLE_LIMIT) repeat (LATENCY + 10) @(posedge aclk);
        if (idle_cycles >= IDLE_LIMIT || sb.pending.size() != 0 || sb.errors != 0) begin
            $display("TEST FAILED");
        end else begin
            $display("TEST PASSED");
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end
endmodule
